FILE: design/satd_pkg.sv
`timescale 1ns / 1ps

package satd_pkg;

  typedef enum logic [2:0] {
    KIND_UINT    = 3'd0,
    KIND_SINT    = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_TOKEN   = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_INT_LEN = 2'd1,
    ERR_SGN_BIN = 2'd2,
    ERR_TRUNC   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HEAD  = 2'd1,
    PH_FIRST = 2'd2,
    PH_DATA  = 2'd3
  } phase_e;

  localparam int unsigned LenW    = 24;
  localparam int unsigned ValW    = 64;
  localparam int unsigned MaxIntB = 8;

  typedef struct packed {
    phase_e            phase;
    logic [1:0]        hdr_left;
    logic [LenW-1:0]   pay_left;
    logic              bin;
    logic              sgn;
    logic              skip;
    logic [ValW-1:0]   acc;
  } state_t;

  localparam state_t IdleSt = '{
    phase:    PH_IDLE,
    hdr_left: 2'd0,
    pay_left: '0,
    bin:      1'b0,
    sgn:      1'b0,
    skip:     1'b0,
    acc:      '0
  };

  typedef struct packed {
    kind_e           kind;
    logic [ValW-1:0] value;
    logic            payload_last;
    err_e            error_code;
    logic            run_last;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

FILE: design/satd_core.sv
`timescale 1ns / 1ps

module satd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              fend_i,
  output satd_pkg::push_t   push_o
);

  satd_pkg::state_t  st_q, st_d;
  logic              m_v;
  satd_pkg::result_t m_r;
  satd_pkg::result_t t_r;
  logic              t_v;
  logic              hd;
  logic [satd_pkg::LenW-1:0] hd_len;
  logic [1:0]        hdr_dec;
  logic [satd_pkg::LenW-1:0] pay_dec;
  logic [satd_pkg::ValW-1:0] base;
  logic [satd_pkg::ValW-1:0] nacc;

  always_comb begin
    st_d    = st_q;
    m_v     = 1'b0;
    m_r     = '{kind: satd_pkg::KIND_UINT, value: '0, payload_last: 1'b0,
                error_code: satd_pkg::ERR_NONE, run_last: 1'b0};
    t_v     = 1'b0;
    hd      = 1'b0;
    hd_len  = '0;
    hdr_dec = st_q.hdr_left - {1'b0, (st_q.hdr_left != 2'd0)};
    pay_dec = st_q.pay_left - {{(satd_pkg::LenW-1){1'b0}}, (st_q.pay_left != '0)};
    base    = '0;
    nacc    = '0;

    unique case (st_q.phase)
      satd_pkg::PH_IDLE: begin
        priority if (!byte_i[7]) begin
          m_v = 1'b1;
          if (byte_i[6]) begin
            m_r.kind  = satd_pkg::KIND_SINT;
            m_r.value = {{(satd_pkg::ValW-6){byte_i[5]}}, byte_i[5:0]};
          end else begin
            m_r.kind  = satd_pkg::KIND_UINT;
            m_r.value = {{(satd_pkg::ValW-6){1'b0}}, byte_i[5:0]};
          end
        end else if (byte_i[7:6] == 2'b10) begin
          st_d.bin = byte_i[5];
          st_d.sgn = byte_i[4];
          hd       = 1'b1;
          hd_len   = {{(satd_pkg::LenW-4){1'b0}}, byte_i[3:0]};
        end else if (byte_i[7:5] == 3'b110) begin
          st_d.bin      = byte_i[4];
          st_d.sgn      = byte_i[3];
          st_d.acc      = {{(satd_pkg::ValW-3){1'b0}}, byte_i[2:0]};
          st_d.hdr_left = 2'd1;
          st_d.phase    = satd_pkg::PH_HEAD;
        end else if (byte_i[7:2] == 6'b111000) begin
          st_d.bin      = byte_i[1];
          st_d.sgn      = byte_i[0];
          st_d.acc      = '0;
          st_d.hdr_left = 2'd3;
          st_d.phase    = satd_pkg::PH_HEAD;
        end else begin
          m_v       = 1'b1;
          m_r.kind  = satd_pkg::KIND_TOKEN;
          m_r.value = {{(satd_pkg::ValW-8){1'b0}}, byte_i};
        end
      end
      satd_pkg::PH_HEAD: begin
        st_d.acc      = {{(satd_pkg::ValW-satd_pkg::LenW){1'b0}}, st_q.acc[15:0], byte_i};
        st_d.hdr_left = hdr_dec;
        if (hdr_dec == 2'd0) begin
          hd     = 1'b1;
          hd_len = {st_q.acc[15:0], byte_i};
        end
      end
      satd_pkg::PH_FIRST, satd_pkg::PH_DATA: begin
        st_d.pay_left = pay_dec;
        if (st_q.phase == satd_pkg::PH_FIRST) begin
          base = (st_q.sgn && byte_i[7]) ? '1 : '0;
        end else begin
          base = st_q.acc;
        end
        nacc = {base[satd_pkg::ValW-9:0], byte_i};
        if (st_q.skip) begin
          m_v = 1'b0;
        end else if (st_q.bin) begin
          m_v              = 1'b1;
          m_r.kind         = satd_pkg::KIND_PAYLOAD;
          m_r.value        = {{(satd_pkg::ValW-8){1'b0}}, byte_i};
          m_r.payload_last = (pay_dec == '0);
        end else begin
          st_d.acc = nacc;
          if (pay_dec == '0) begin
            m_v       = 1'b1;
            m_r.kind  = st_q.sgn ? satd_pkg::KIND_SINT : satd_pkg::KIND_UINT;
            m_r.value = nacc;
          end
        end
        st_d.phase = satd_pkg::PH_DATA;
        if (pay_dec == '0) begin
          st_d = satd_pkg::IdleSt;
        end
      end
      default: begin
        st_d = satd_pkg::IdleSt;
      end
    endcase

    // Header completion decides between an empty marker, an error or data.
    if (hd) begin
      st_d.pay_left = hd_len;
      st_d.acc      = '0;
      st_d.hdr_left = 2'd0;
      if (st_d.bin && st_d.sgn) begin
        m_v            = 1'b1;
        m_r.kind       = satd_pkg::KIND_ERROR;
        m_r.error_code = satd_pkg::ERR_SGN_BIN;
        st_d.skip      = 1'b1;
      end else if (st_d.bin) begin
        if (hd_len == '0) begin
          m_v      = 1'b1;
          m_r.kind = satd_pkg::KIND_EMPTY;
        end
      end else if (hd_len == '0 || hd_len > satd_pkg::LenW'(satd_pkg::MaxIntB)) begin
        m_v            = 1'b1;
        m_r.kind       = satd_pkg::KIND_ERROR;
        m_r.error_code = satd_pkg::ERR_INT_LEN;
        st_d.skip      = 1'b1;
      end
      if (hd_len == '0) begin
        st_d = satd_pkg::IdleSt;
      end else begin
        st_d.phase = satd_pkg::PH_FIRST;
      end
    end

    if (fend_i && st_d.phase != satd_pkg::PH_IDLE) begin
      t_v  = 1'b1;
      st_d = satd_pkg::IdleSt;
    end

    t_r = '{kind: satd_pkg::KIND_ERROR, value: '0, payload_last: 1'b0,
            error_code: satd_pkg::ERR_TRUNC, run_last: 1'b1};
    m_r.run_last = !t_v;

    if (m_v) begin
      push_o.v0 = step_i;
      push_o.v1 = step_i && t_v;
      push_o.r0 = m_r;
      push_o.r1 = t_r;
    end else begin
      push_o.v0 = step_i && t_v;
      push_o.v1 = 1'b0;
      push_o.r0 = t_r;
      push_o.r1 = t_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= satd_pkg::IdleSt;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

FILE: design/satd_fifo.sv
`timescale 1ns / 1ps

module satd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  satd_pkg::push_t   push_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output satd_pkg::result_t res_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  satd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;
  logic [PtrW-1:0]   wp1;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rp_q];
  assign room_o  = (cnt_q <= CntW'(Depth - 2)) || ((cnt_q == CntW'(Depth - 1)) && pop);
  assign wp1     = wp_q + PtrW'(1);

  always_comb begin
    wp_d  = wp_q + PtrW'(push_i.v0) + PtrW'(push_i.v1);
    rp_d  = rp_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.v0) + CntW'(push_i.v1) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wp1] <= push_i.r1;
    end
  end

endmodule

FILE: design/storage_atom_stream_decoder.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata bits                                  tuser      tlast
// s_axis    in   [7:0] data_byte                             -          frame_end
// m_axis    out  [63:0] value, [64] payload_last,            [2:0] kind run_last
//                [66:65] error_code, [71:67] zero
// A byte is taken into the input register and decoded from there once the
// result queue has room; its results, up to two, land in a four-entry result queue.
// One byte per cycle is sustained while bytes give at most one result each and
// m_axis is not stalled; a byte with two results drains one result at a time through the single output port.
// Reset is asynchronous and active low and returns the decoder to idle.
// Output stalls back up through the queue to s_axis_tready_o.

module storage_atom_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // frame_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] value, [64] payload_last, [66:65] error_code
  output logic [2:0]  m_axis_tuser_o,   // [2:0] kind
  output logic        m_axis_tlast_o    // run_last
);

  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              in_fend_q;
  logic              room;
  logic              step;
  satd_pkg::push_t   push;
  satd_pkg::result_t res;

  assign step            = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_fend_q <= s_axis_tlast_i;
    end
  end

  satd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .fend_i (in_fend_q),
    .push_o (push)
  );

  satd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  assign m_axis_tdata_o = {5'd0, res.error_code, res.payload_last, res.value};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.run_last;

endmodule

FILE: design/satd_chk.sv
`timescale 1ns / 1ps

module satd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_i,
  input logic [2:0]  m_axis_tuser_i,
  input logic        m_axis_tlast_i
);

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |->
      ((m_axis_tuser_i == satd_pkg::KIND_ERROR) == (m_axis_tdata_i[66:65] != satd_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tuser_i <= satd_pkg::KIND_ERROR)
    else $error("result kind out of range");

  a_last_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tdata_i[64]) |->
      (m_axis_tuser_i == satd_pkg::KIND_PAYLOAD && m_axis_tlast_i))
    else $error("payload end mark on a result that is not a final payload byte");

  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tdata_i[66:65] == satd_pkg::ERR_TRUNC) |->
      (m_axis_tlast_i && m_axis_tdata_i[63:0] == 64'd0))
    else $error("truncation error is not the closing result of its byte");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=>
      (m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i)))
    else $error("stalled output transaction changed");

endmodule

bind storage_atom_stream_decoder satd_chk u_satd_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
